// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the bounding box crop block: item structs,
// operation and register codes, and the controller to datapath interface.
// ----------------------------------------------------------------------------
package bbc_pkg;

	localparam int SIZE_W       = 7;
	localparam int SIZE_MAX     = (1 << SIZE_W) - 1;
	localparam int TOT_W        = 2 * SIZE_W;
	localparam int EMIT_W       = SIZE_W + 1;
	localparam int PIX_W        = 8;
	localparam int BORDER_TOTAL = 2;
	localparam int CFG_IDX_W    = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_FETCH   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	typedef struct packed {
		logic [1:0]       kind;
		logic [PIX_W-1:0] pixel_in;
	} item_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel_out;
		logic [SIZE_W-1:0] crop_width;
		logic [SIZE_W-1:0] crop_height;
		logic              valid_res;
		logic              last;
	} result_t;

	typedef struct packed {
		logic load;
		logic fetch;
		logic restart;
		logic div_start;
		logic div_commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/bbc_ram.sv =====
// ----------------------------------------------------------------------------
// bbc_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bbc_div.sv =====
// ----------------------------------------------------------------------------
// bbc_div
// Bit-serial restoring divider, one quotient bit per cycle. Splits the load
// count into row and column after an image size change.
// ----------------------------------------------------------------------------
module bbc_div #(
	parameter int NUM_W = 13
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUM_W-1:0]          dividend,
	input  logic [bbc_pkg::SIZE_W-1:0] divisor,
	output logic [bbc_pkg::SIZE_W-1:0] quot,
	output logic [bbc_pkg::SIZE_W-1:0] rem,
	output logic                      done
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]           num_q;
	logic [NUM_W-1:0]           quot_q;
	logic [bbc_pkg::SIZE_W-1:0] rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [bbc_pkg::SIZE_W:0]   trial;
	logic [bbc_pkg::SIZE_W:0]   diff;
	logic                       ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			quot_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			quot_q <= NUM_W'({quot_q, ge});
			rem_q  <= ge ? diff[bbc_pkg::SIZE_W-1:0] : trial[bbc_pkg::SIZE_W-1:0];
		end
	end

	assign quot = bbc_pkg::SIZE_W'(quot_q);
	assign rem  = rem_q;
	assign done = done_q;

endmodule

// ===== rtl/bbc_dp.sv =====
// ----------------------------------------------------------------------------
// bbc_dp
// Datapath: size registers, load counters, bounding box tracking, image
// store, emit position and the result register.
// ----------------------------------------------------------------------------
module bbc_dp #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bbc_pkg::cmd_t                 cmd,
	output bbc_pkg::sts_t                 sts,
	input  logic [bbc_pkg::PIX_W-1:0]     pixel_in,
	input  logic                          cfg_we,
	input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbc_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                          result_stall,
	output bbc_pkg::result_t              result,
	output logic                          result_valid
);

	localparam int CAP_W = (MAX_WIDTH > bbc_pkg::SIZE_MAX) ? bbc_pkg::SIZE_MAX : MAX_WIDTH;
	localparam int CAP_H = (MAX_HEIGHT > bbc_pkg::SIZE_MAX) ? bbc_pkg::SIZE_MAX : MAX_HEIGHT;
	localparam int LC_W = $clog2(CAP_W * CAP_H + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = bbc_pkg::SIZE_W;
	localparam int EW = bbc_pkg::EMIT_W;
	localparam logic [SW-1:0] CAP_W_V = SW'(CAP_W);
	localparam logic [SW-1:0] CAP_H_V = SW'(CAP_H);
	localparam logic [EW-1:0] FRAME_ADD = EW'(bbc_pkg::BORDER_TOTAL + 1);
	localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

	logic [SW-1:0] width_q, height_q;
	logic [SW-1:0] w_eff, h_eff;
	logic [bbc_pkg::TOT_W-1:0] total;
	logic loading;

	logic [LC_W-1:0] lc_q;
	logic [SW-1:0] row_q, col_q;
	logic [SW-1:0] top_q, bottom_q, left_q, right_q;
	logic any_q;
	logic [EW-1:0] emit_row_q, emit_col_q;

	logic [SW-1:0] div_quot, div_rem;
	logic div_done;

	logic [AW-1:0] waddr, raddr;
	logic ram_we;
	logic [bbc_pkg::PIX_W-1:0] rdata;

	logic [EW-1:0] cw, ch;
	logic fetch_ok, interior, frame_last;
	logic [SW-1:0] rd_r, rd_c;

	logic ok_s1, interior_s1, last_s1;
	logic [SW-1:0] cw_s1, ch_s1;

	bbc_pkg::result_t res_q;
	logic out_valid_q;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bbc_pkg::SIZE_RESET;
			height_q <= bbc_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bbc_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bbc_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = (width_q == '0) ? SW'(1) : ((width_q > CAP_W_V) ? CAP_W_V : width_q);
		h_eff = (height_q == '0) ? SW'(1) : ((height_q > CAP_H_V) ? CAP_H_V : height_q);
	end

	assign total   = bbc_pkg::TOT_W'(w_eff) * bbc_pkg::TOT_W'(h_eff);
	assign loading = bbc_pkg::TOT_W'(lc_q) < total;

	bbc_div #(
		.NUM_W(LC_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(lc_q),
		.divisor (w_eff),
		.quot    (div_quot),
		.rem     (div_rem),
		.done    (div_done)
	);

	// fetch geometry
	always_comb begin
		cw = EW'(right_q) - EW'(left_q) + FRAME_ADD;
		ch = EW'(bottom_q) - EW'(top_q) + FRAME_ADD;
		fetch_ok = !loading && (emit_row_q < ch);
		interior = (emit_row_q != '0) && (emit_row_q != ch - 1'b1) &&
			(emit_col_q != '0) && (emit_col_q != cw - 1'b1);
		frame_last = (emit_row_q == ch - 1'b1) && (emit_col_q == cw - 1'b1);
		rd_r = SW'(EW'(top_q) + emit_row_q - 1'b1);
		rd_c = SW'(EW'(left_q) + emit_col_q - 1'b1);
	end

	assign ram_we = cmd.load && loading;
	assign waddr  = AW'(row_q) * ROW_STRIDE + AW'(col_q);
	assign raddr  = AW'(rd_r) * ROW_STRIDE + AW'(rd_c);

	bbc_ram #(
		.DATA_W(bbc_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(pixel_in),
		.re   (cmd.fetch),
		.raddr(raddr),
		.rdata(rdata)
	);

	// load position, bounds and emit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q       <= '0;
			row_q      <= '0;
			col_q      <= '0;
			top_q      <= '0;
			bottom_q   <= '0;
			left_q     <= '0;
			right_q    <= '0;
			any_q      <= 1'b0;
			emit_row_q <= '0;
			emit_col_q <= '0;
		end else if (cmd.restart) begin
			lc_q       <= '0;
			row_q      <= '0;
			col_q      <= '0;
			top_q      <= '0;
			bottom_q   <= '0;
			left_q     <= '0;
			right_q    <= '0;
			any_q      <= 1'b0;
			emit_row_q <= '0;
			emit_col_q <= '0;
		end else if (cmd.div_commit) begin
			row_q <= div_quot;
			col_q <= div_rem;
		end else if (ram_we) begin
			lc_q <= lc_q + 1'b1;
			if (EW'(col_q) + 1'b1 >= EW'(w_eff)) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
			if (pixel_in != '0) begin
				any_q <= 1'b1;
				if (!any_q) begin
					top_q    <= row_q;
					bottom_q <= row_q;
					left_q   <= col_q;
					right_q  <= col_q;
				end else begin
					if (row_q < top_q) begin
						top_q <= row_q;
					end
					if (row_q > bottom_q) begin
						bottom_q <= row_q;
					end
					if (col_q < left_q) begin
						left_q <= col_q;
					end
					if (col_q > right_q) begin
						right_q <= col_q;
					end
				end
			end
		end else if (cmd.fetch && fetch_ok) begin
			if (emit_col_q + 1'b1 >= cw) begin
				emit_col_q <= '0;
				emit_row_q <= emit_row_q + 1'b1;
			end else begin
				emit_col_q <= emit_col_q + 1'b1;
			end
		end
	end

	// fetch stage, waits for the store read
	always_ff @(posedge clk) begin
		if (cmd.fetch) begin
			ok_s1       <= fetch_ok;
			interior_s1 <= interior;
			last_s1     <= frame_last;
			cw_s1       <= cw[SW-1:0];
			ch_s1       <= ch[SW-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.pixel_out   <= (ok_s1 && interior_s1) ? rdata : '0;
			res_q.crop_width  <= ok_s1 ? cw_s1 : '0;
			res_q.crop_height <= ok_s1 ? ch_s1 : '0;
			res_q.valid_res   <= ok_s1;
			res_q.last        <= ok_s1 && last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result       = res_q;
	assign result_valid = out_valid_q;
	assign sts.div_done = div_done;
	assign sts.out_busy = out_valid_q && result_stall;

endmodule

// ===== rtl/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbc_ctrl
// Controller: decodes accepted beats, sequences the store read of a fetch
// and the row and column recompute after a size register write.
// ----------------------------------------------------------------------------
module bbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic [1:0]    kind,
	input  logic          cfg_we,
	input  bbc_pkg::sts_t sts,
	output logic          item_stall,
	output bbc_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	logic [1:0] state_q, state_nxt;
	logic acc;

	assign item_stall = (state_q != ST_IDLE) || cfg_we;
	assign acc        = item_valid && !item_stall;

	always_comb begin
		cmd.load       = acc && (kind == bbc_pkg::KIND_LOAD);
		cmd.fetch      = acc && (kind == bbc_pkg::KIND_FETCH);
		cmd.restart    = acc && (kind == bbc_pkg::KIND_RESTART);
		cmd.div_start  = state_q == ST_PREP;
		cmd.div_commit = (state_q == ST_DIV) && sts.div_done;
		cmd.out_load   = (state_q == ST_READ) && !sts.out_busy;
	end

	always_comb begin
		state_nxt = state_q;
		priority if (cfg_we) begin
			state_nxt = ST_PREP;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.fetch) state_nxt = ST_READ;
				ST_PREP: state_nxt = ST_DIV;
				ST_DIV:  if (sts.div_done) state_nxt = ST_IDLE;
				ST_READ: if (!sts.out_busy) state_nxt = ST_IDLE;
				default: state_nxt = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/bounding_box_crop_with_border.sv =====
// ----------------------------------------------------------------------------
// bounding_box_crop_with_border
// Loads a grey image, tracks the bounding box of nonzero pixels and returns
// the box framed by a one-pixel zero border, one pixel per fetch.
// Load and restart beats: one per cycle while no size write or fetch stalls.
// Fetch: the store read is registered, then the result register is loaded;
// no beat is taken before that load, and a held result stalls the next fetch until it is taken.
// After a size register write the row/column position is recomputed by a
// bit-serial divider; beats stall from the write until the divider is done
// and the new position is committed.
// Reset clears counters, bounds and emit position and sets both sizes to 64;
// the image store is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
module bounding_box_crop_with_border #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  bbc_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output bbc_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bbc_pkg::SIZE_W-1:0]    cfg_data
);

	bbc_pkg::cmd_t cmd;
	bbc_pkg::sts_t sts;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	bbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.kind      (item.kind),
		.cfg_we    (cfg_we),
		.sts       (sts),
		.item_stall(item_stall),
		.cmd       (cmd)
	);

	bbc_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pixel_in    (item.pixel_in),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_stall(result_stall),
		.result      (result),
		.result_valid(result_valid)
	);

	a_cfg_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !(item_valid && !item_stall))
		else $error("size write taken together with an input beat");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.valid_res) |->
		(result.pixel_out == '0 && result.crop_width == '0 && result.crop_height == '0))
		else $error("invalid result carries nonzero fields");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> result.valid_res)
		else $error("last flagged on an invalid result");

	a_fetch_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.kind == bbc_pkg::KIND_FETCH) |=> item_stall)
		else $error("beat accepted while a fetch read is pending");

endmodule

// ===== verif/bounding_box_crop_with_border_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_box_crop_with_border_tb
// Self-checking bench for the bounding box crop block. A driver process sends
// load, fetch, restart and spare-code beats from a pending queue filled by the
// stimulus thread. Each accepted beat goes through a local model of the crop,
// which queues the framed pixel that a fetch should return. A monitor process
// compares each result beat field by field against the oldest queued pixel.
// Image sizes change only while the block is idle. Both sides stall in random
// bursts, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module bounding_box_crop_with_border_tb;
	import bbc_pkg::*;

	localparam int MAX_W = 64;
	localparam int MAX_H = 64;
	localparam int SETTLE = 24;
	localparam int ITEM_GOAL = 1800;
	localparam int LONG_HOLD = 200;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;

	item_t beats_to_send [$];
	result_t pixels_due [$];
	result_t due_beat;
	int unsigned beats_made = 0;
	int unsigned fail_count = 0;
	int unsigned fetch_beats;
	int unsigned tx_gap, rx_gap, hold_left;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	logic rx_pause;
	logic hold_used;

	// local model of the crop
	logic [PIX_W-1:0] frame_mem [MAX_W*MAX_H];
	logic [SIZE_W-1:0] size_w_reg = SIZE_RESET;
	logic [SIZE_W-1:0] size_h_reg = SIZE_RESET;
	int unsigned px_loaded = 0;
	int unsigned box_top = 0, box_bottom = 0, box_left = 0, box_right = 0;
	int unsigned out_row = 0, out_col = 0;
	bit box_seen = 1'b0;

	bounding_box_crop_with_border #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned hi);
		if (v == 0)
			return 1;
		if (32'(v) > hi)
			return hi;
		return 32'(v);
	endfunction

	function automatic void predict_crop(item_t beat);
		int unsigned w, h, row, col, cw, ch;
		result_t res;
		w = eff_size(size_w_reg, MAX_W);
		h = eff_size(size_h_reg, MAX_H);
		res = '0;
		case (beat.kind)
		KIND_LOAD: begin
			if (px_loaded < w * h) begin
				row = px_loaded / w;
				col = px_loaded % w;
				frame_mem[row * MAX_W + col] = beat.pixel_in;
				if (beat.pixel_in != 0) begin
					if (!box_seen) begin
						box_top = row;
						box_bottom = row;
						box_left = col;
						box_right = col;
						box_seen = 1'b1;
					end else begin
						if (row < box_top) box_top = row;
						if (row > box_bottom) box_bottom = row;
						if (col < box_left) box_left = col;
						if (col > box_right) box_right = col;
					end
				end
				px_loaded++;
			end
		end
		KIND_RESTART: begin
			px_loaded = 0;
			box_top = 0;
			box_bottom = 0;
			box_left = 0;
			box_right = 0;
			box_seen = 1'b0;
			out_row = 0;
			out_col = 0;
		end
		KIND_FETCH: begin
			cw = box_right - box_left + 1 + BORDER_TOTAL;
			ch = box_bottom - box_top + 1 + BORDER_TOTAL;
			if (px_loaded >= w * h && out_row < ch) begin
				if (out_row != 0 && out_row != ch - 1 && out_col != 0 && out_col != cw - 1)
					res.pixel_out = frame_mem[(box_top + out_row - 1) * MAX_W
						+ box_left + out_col - 1];
				res.crop_width = SIZE_W'(cw);
				res.crop_height = SIZE_W'(ch);
				res.valid_res = 1'b1;
				res.last = (out_row == ch - 1) && (out_col == cw - 1);
				out_col++;
				if (out_col >= cw) begin
					out_col = 0;
					out_row++;
				end
			end
			pixels_due.push_back(res);
		end
		default: ;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			tx_gap <= 0;
			fetch_beats <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_crop(item);
				if (item.kind == KIND_FETCH)
					fetch_beats <= fetch_beats + 1;
			end
			if (!item_valid || !item_stall) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					item_valid <= 1'b0;
				end else if ($urandom_range(0, 99) < tx_idle_pct) begin
					tx_gap <= $urandom_range(0, 15);
					item_valid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					item <= beats_to_send.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, while fetches keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && fetch_beats >= 40) begin
			hold_left <= LONG_HOLD;
			hold_used <= 1'b1;
		end
	end

	assign result_stall = rx_pause || (hold_left != 0);

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_pause <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pixels_due.size() == 0) begin
					$error("result beat with no fetch outstanding");
					fail_count++;
				end else begin
					due_beat = pixels_due.pop_front();
					check_field("pixel_out", due_beat.pixel_out, result.pixel_out);
					check_field("crop_width", 8'(due_beat.crop_width),
						8'(result.crop_width));
					check_field("crop_height", 8'(due_beat.crop_height),
						8'(result.crop_height));
					check_field("valid_res", 8'(due_beat.valid_res), 8'(result.valid_res));
					check_field("last", 8'(due_beat.last), 8'(result.last));
				end
			end
			if (rx_gap != 0) begin
				rx_gap <= rx_gap - 1;
				rx_pause <= 1'b1;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				rx_gap <= $urandom_range(0, 15);
				rx_pause <= 1'b1;
			end else begin
				rx_pause <= 1'b0;
			end
		end
	end

	task automatic push_beat(logic [1:0] k, logic [PIX_W-1:0] px);
		item_t b;
		b.kind = k;
		b.pixel_in = px;
		beats_to_send.push_back(b);
		if (k != KIND_SPARE)
			beats_made++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (beats_to_send.size() != 0 || item_valid || pixels_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			size_w_reg = val;
		else
			size_h_reg = val;
	endtask

	// one frame: restart, full load with some noise, then fetch the framed crop
	task automatic queue_frame(logic [SIZE_W-1:0] wv, logic [SIZE_W-1:0] hv);
		int unsigned w, h, n, row, col, cut, style;
		int unsigned top, bot, lft, rgt;
		bit seen;
		logic [PIX_W-1:0] px;
		w = eff_size(wv, MAX_W);
		h = eff_size(hv, MAX_H);
		style = $urandom_range(0, 9);
		cut = w * h;
		if (w * h <= 64 && $urandom_range(0, 9) == 0)
			cut = $urandom_range(0, w * h - 1);
		seen = 1'b0;
		top = 0;
		bot = 0;
		lft = 0;
		rgt = 0;
		push_beat(KIND_RESTART, PIX_W'($urandom_range(0, 255)));
		for (int i = 0; i < w * h; i++) begin
			if ($urandom_range(0, 99) < 4)
				push_beat($urandom_range(0, 1) ? KIND_FETCH : KIND_SPARE,
					PIX_W'($urandom_range(0, 255)));
			if (i == cut)
				push_beat(KIND_RESTART, PIX_W'($urandom_range(0, 255)));
			if (style == 0)
				px = '0;
			else if (style < 5)
				px = ($urandom_range(0, 9) == 0) ? PIX_W'($urandom_range(1, 255)) :
					PIX_W'(0);
			else
				px = $urandom_range(0, 1) ? PIX_W'($urandom_range(0, 255)) : PIX_W'(0);
			push_beat(KIND_LOAD, px);
			if (px != 0) begin
				row = i / w;
				col = i % w;
				if (!seen) begin
					top = row;
					bot = row;
					lft = col;
					rgt = col;
					seen = 1'b1;
				end else begin
					if (row > bot) bot = row;
					if (col < lft) lft = col;
					if (col > rgt) rgt = col;
				end
			end
		end
		n = (rgt - lft + 3) * (bot - top + 3) + $urandom_range(0, 2);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 3)
				push_beat(KIND_SPARE, PIX_W'($urandom_range(0, 255)));
			if (cut == w * h && $urandom_range(0, 99) < 2)
				push_beat(KIND_LOAD, PIX_W'($urandom_range(0, 255)));
			push_beat(KIND_FETCH, PIX_W'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int unsigned p;
		int unsigned sel;
		logic [SIZE_W-1:0] wv, hv;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: fetch at reset sizes, spare code, restart
		@(negedge clk);
		push_beat(KIND_FETCH, 8'h00);
		push_beat(KIND_SPARE, 8'hff);
		push_beat(KIND_RESTART, 8'h00);
		wait_idle();

		// zero width acts as one: all-zero 1x1 image, load past full, fetch past last
		write_size(REG_IMAGE_WIDTH, 7'd0);
		write_size(REG_IMAGE_HEIGHT, 7'd1);
		@(negedge clk);
		push_beat(KIND_FETCH, 8'hff);
		push_beat(KIND_LOAD, 8'h00);
		push_beat(KIND_LOAD, 8'hff);
		repeat (10) push_beat(KIND_FETCH, 8'h00);
		wait_idle();

		// sizes changed part-way through a load
		write_size(REG_IMAGE_WIDTH, 7'd2);
		write_size(REG_IMAGE_HEIGHT, 7'd2);
		@(negedge clk);
		push_beat(KIND_RESTART, 8'h00);
		push_beat(KIND_LOAD, 8'hff);
		push_beat(KIND_LOAD, 8'h00);
		wait_idle();
		write_size(REG_IMAGE_HEIGHT, 7'd1);
		@(negedge clk);
		repeat (10) push_beat(KIND_FETCH, 8'h00);

		p = 0;
		while (beats_made < ITEM_GOAL) begin
			sel = $urandom_range(0, 9);
			if (p == 0) begin
				wv = 7'd127;
				hv = 7'd0;
			end else if (p == 1) begin
				wv = 7'd1;
				hv = 7'd64;
			end else if (sel == 0) begin
				wv = SIZE_W'($urandom_range(64, 127));
				hv = SIZE_W'($urandom_range(0, 2));
			end else if (sel == 1) begin
				wv = SIZE_W'($urandom_range(0, 2));
				hv = SIZE_W'($urandom_range(64, 127));
			end else begin
				wv = SIZE_W'($urandom_range(0, 8));
				hv = SIZE_W'($urandom_range(1, 8));
			end
			wait_idle();
			write_size(REG_IMAGE_WIDTH, wv);
			write_size(REG_IMAGE_HEIGHT, hv);
			@(negedge clk);
			if (beats_made + 300 > ITEM_GOAL) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
				rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
			end
			queue_frame(wv, hv);
			p++;
		end
		wait_idle();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
